@@ rtl/core/pfla_pkg.sv @@
// shared types, constants and codes of the page free list allocator
package pfla_pkg;

	localparam int STACK_DEPTH = 32768;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 32;
	localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
	localparam int MP_W        = PAGE_W + 1;
	localparam int AVAIL_W     = MP_W + 1;
	localparam int MAX_PAGES   = 1 << PAGE_W;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = MP_W;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISALIGN  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_STACKFULL = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_PAGES  = 1'd1;

	// classified operation kinds
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_NOP     = 3'd0;
	localparam logic [KIND_W-1:0] K_INIT    = 3'd1;
	localparam logic [KIND_W-1:0] K_ALLOC   = 3'd2;
	localparam logic [KIND_W-1:0] K_FREE    = 3'd3;
	localparam logic [KIND_W-1:0] K_BADFREE = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PAGE_W-1:0] page;
	} op_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   page_addr;
		logic [STATUS_W-1:0] status;
		logic [AVAIL_W-1:0]  avail_count;
	} res_t;

endpackage

@@ rtl/core/pfla_front.sv @@
// command intake: classifies beats and buffers them in a two-entry queue
module pfla_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [pfla_pkg::CMD_W-1:0]    cmd,
	input  logic [pfla_pkg::ADDR_W-1:0]   addr,
	output logic                          op_valid,
	output pfla_pkg::op_t                 op,
	input  logic                          op_pop
);
	import pfla_pkg::*;

	op_t        q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	op_t        cls;
	logic       do_push;
	logic       do_pop;

	// decode the command and check page alignment up front
	always_comb begin
		cls.page = addr[ADDR_W-1:PAGE_SHIFT];
		unique case (cmd)
			CMD_INIT:  cls.kind = K_INIT;
			CMD_ALLOC: cls.kind = K_ALLOC;
			CMD_FREE:  cls.kind = (|addr[PAGE_SHIFT-1:0]) ? K_BADFREE : K_FREE;
			default:   cls.kind = K_NOP;
		endcase
	end

	assign full     = (cnt_q == 2'd2);
	assign do_push  = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign do_pop   = op_pop && op_valid;
	assign op       = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ rtl/core/pfla_back.sv @@
// execution side: page stack memory, run counters, config and result queue
module pfla_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              op_valid,
	input  pfla_pkg::op_t                     op,
	output logic                              op_pop,
	input  logic                              cfg_we,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pfla_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              res_empty,
	output pfla_pkg::res_t                    res,
	input  logic                              res_pop
);
	import pfla_pkg::*;

	localparam logic BK_RUN  = 1'b0;
	localparam logic BK_READ = 1'b1;

	logic [PAGE_W-1:0] stack_mem [STACK_DEPTH];
	logic [PAGE_W-1:0] rd_data_q;

	logic              state_q;
	logic              state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  cnt_dec;
	logic [MP_W-1:0]   left_q;
	logic [MP_W-1:0]   left_d;
	logic [PAGE_W-1:0] base_q;
	logic [PAGE_W-1:0] base_d;
	logic [PAGE_W-1:0] ffp_q;
	logic [MP_W-1:0]   mem_pages_q;

	logic [MP_W-1:0]   top_pages;
	logic [MP_W-1:0]   ffp_ext;
	logic [MP_W-1:0]   run_sum;
	logic [MP_W-1:0]   init_left;

	logic              take;
	logic              mem_we;
	logic              mem_re;
	logic              res_we;
	res_t              res_d;

	res_t              rq_q [2];
	logic              rq_wr_q;
	logic              rq_rd_q;
	logic [1:0]        rq_cnt_q;
	logic              rq_pop;

	assign take    = op_valid && (state_q == BK_RUN) && (rq_cnt_q != 2'd2);
	assign op_pop  = take;
	assign cnt_dec = cnt_q - CNT_W'(1);

	assign ffp_ext   = {1'b0, ffp_q};
	assign top_pages = (mem_pages_q > MP_W'(MAX_PAGES)) ? MP_W'(MAX_PAGES) : mem_pages_q;
	assign init_left = (top_pages > ffp_ext) ? (top_pages - ffp_ext) : '0;
	assign run_sum   = {1'b0, base_q} + left_q - MP_W'(1);

	always_comb begin
		state_d          = state_q;
		cnt_d            = cnt_q;
		left_d           = left_q;
		base_d           = base_q;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		res_we           = 1'b0;
		res_d.page_addr  = '0;
		res_d.status     = ST_OK;
		if (state_q == BK_READ) begin
			// popped entry came back from the memory
			res_we          = 1'b1;
			res_d.page_addr = {rd_data_q, {PAGE_SHIFT{1'b0}}};
			state_d         = BK_RUN;
		end else if (take) begin
			unique case (op.kind)
				K_INIT: begin
					res_we       = 1'b1;
					cnt_d        = '0;
					base_d       = ffp_q;
					left_d       = init_left;
					res_d.status = (init_left == '0) ? ST_OOM : ST_OK;
				end
				K_ALLOC: begin
					if (cnt_q != '0) begin
						mem_re  = 1'b1;
						cnt_d   = cnt_dec;
						state_d = BK_READ;
					end else if (left_q != '0) begin
						res_we          = 1'b1;
						left_d          = left_q - MP_W'(1);
						res_d.page_addr = {run_sum[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
					end else begin
						res_we       = 1'b1;
						res_d.status = ST_OOM;
					end
				end
				K_FREE: begin
					res_we = 1'b1;
					if (cnt_q == CNT_W'(STACK_DEPTH)) begin
						res_d.status = ST_STACKFULL;
					end else begin
						mem_we = 1'b1;
						cnt_d  = cnt_q + CNT_W'(1);
					end
				end
				K_BADFREE: begin
					res_we       = 1'b1;
					res_d.status = ST_MISALIGN;
				end
				default: begin
					res_we = 1'b1;
				end
			endcase
		end
		res_d.avail_count = AVAIL_W'(cnt_d) + AVAIL_W'(left_d);
	end

	// page stack storage, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[cnt_q[SP_W-1:0]] <= op.page;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[cnt_dec[SP_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			cnt_q       <= '0;
			left_q      <= '0;
			base_q      <= '0;
			ffp_q       <= '0;
			mem_pages_q <= MP_W'(25600);
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			base_q  <= base_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_FIRST_FREE: ffp_q       <= cfg_data[PAGE_W-1:0];
					CFG_MEM_PAGES:  mem_pages_q <= cfg_data;
					default:        ;
				endcase
			end
		end
	end

	// result queue
	assign res_empty = (rq_cnt_q == 2'd0);
	assign rq_pop    = res_pop && !res_empty;
	assign res       = rq_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (res_we) begin
			rq_q[rq_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (res_we) begin
				rq_wr_q <= ~rq_wr_q;
			end
			if (rq_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			rq_cnt_q <= rq_cnt_q + {1'b0, res_we} - {1'b0, rq_pop};
		end
	end

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |=> state_q == BK_RUN)
		else $error("stack read state held more than one cycle");

	a_read_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == BK_READ && cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("stack pop did not enter read state");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_we |-> (rq_cnt_q != 2'd2))
		else $error("result written into full queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("stack push did not advance count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

endmodule

@@ rtl/core/page_free_list_allocator_core.sv @@
// top level of the lifo page allocator: intake queue, execution side, ports
// results: a result is written into the result queue when its command beat is taken; an
//   allocate served from the page stack first registers its stack read, then writes its result
// throughput: one command per cycle while the result queue has room; an allocate that pops
//   the stack holds the execution side in its read state because of the registered stack read
// reset: asynchronous active low; clears both queues, the stack count and the initial run,
//   the start page register to 0 and mem_pages to 25600; stack memory contents are not cleared
module page_free_list_allocator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side
	input  logic                              push,
	output logic                              full,
	input  logic [pfla_pkg::CMD_W-1:0]        cmd,
	input  logic [pfla_pkg::ADDR_W-1:0]       addr,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output logic [pfla_pkg::ADDR_W-1:0]       page_addr,
	output logic [pfla_pkg::STATUS_W-1:0]     status,
	output logic [pfla_pkg::AVAIL_W-1:0]      avail_count,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pfla_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pfla_pkg::*;

	// classified command handed from intake to execution
	logic op_valid;
	op_t  op;
	logic op_pop;
	res_t res;

	// intake: decode cmd, flag misaligned frees, buffer two beats
	pfla_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.addr     (addr),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	// execution: page stack, initial run counters and the result queue
	pfla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.res_empty (empty),
		.res       (res),
		.res_pop   (pop)
	);

	// result beat fields straight from the head of the result queue
	assign page_addr   = res.page_addr;
	assign status      = res.status;
	assign avail_count = res.avail_count;

endmodule
